// File: rtl/bcdss_pkg.sv
`default_nettype none
package bcdss_pkg;

	// one decimal digit, 0..9
	typedef logic [3:0] digit_t;

	// scan position codes; zero is never reached from reset
	typedef enum logic [1:0] {
		SCAN_IDLE     = 2'd0,
		SCAN_UNITS    = 2'd1,
		SCAN_TENS     = 2'd2,
		SCAN_HUNDREDS = 2'd3
	} scan_pos_t;

	// one-hot digit enables
	localparam logic [2:0] DIG_NONE     = 3'b000;
	localparam logic [2:0] DIG_HUNDREDS = 3'b001;
	localparam logic [2:0] DIG_TENS     = 3'b010;
	localparam logic [2:0] DIG_UNITS    = 3'b100;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// decimal point segment
	localparam logic [7:0] SEG_DP = 8'h80;

	// common-cathode segment table, a..g in bits 0..6
	function automatic logic [7:0] seg_of(input digit_t d);
		logic [7:0] s;
		unique case (d)
			4'd0:    s = 8'h3F;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5B;
			4'd3:    s = 8'h4F;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6D;
			4'd6:    s = 8'h7D;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// File: rtl/bcd_seven_segment_scan_driver.sv
`default_nettype none
// Three-digit multiplexed seven-segment driver with an ADC pass-through byte.
// Each input word is either an ADC sample or a scan tick. A pass-through
// sample updates passthrough_byte; a display sample x is stored as the
// decimal digits of 2x+2. Each tick lights the next digit (hundreds, tens,
// units, then wrap) with the hundreds decimal point on. Every word gives one
// result word carrying the current segment, digit and pass-through latches.
// Throughput is one word per cycle while out_stall is low; a word passes the input
// register, then the result register, which holds the latch state itself.
module bcd_seven_segment_scan_driver (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       req_type,
	input  wire logic       sample_channel_passthrough,
	input  wire logic [7:0] adc_sample,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      segment_drive,
	output logic [2:0]      digit_enable,
	output logic [7:0]      passthrough_byte
);
	import bcdss_pkg::*;

	// input register
	logic       valid_s1;
	logic       req_s1;
	logic       pass_s1;
	logic [7:0] sample_s1;

	// block state; the result register is the latch state
	digit_t     hund_q, tens_q, units_q;
	scan_pos_t  scan_q;
	logic       out_valid_q;
	logic [7:0] seg_q;
	logic [2:0] dig_q;
	logic [7:0] pass_q;

	logic       advance;
	logic       take_in;

	// decimal split of 2x+2
	logic [9:0]  value;
	logic [2:0]  hund_n;
	logic [6:0]  rem_n;
	logic [14:0] tens_prod;
	digit_t      tens_n;
	digit_t      units_n;
	logic [6:0]  tens_x10;
	logic [9:0]  hund_x100;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	// split the sample in stage one; remainder below 100 divides by 10 via *205>>11
	always_comb begin
		value = {1'b0, sample_s1, 1'b0} + 10'd2;
		if (value >= 10'd500)      hund_n = 3'd5;
		else if (value >= 10'd400) hund_n = 3'd4;
		else if (value >= 10'd300) hund_n = 3'd3;
		else if (value >= 10'd200) hund_n = 3'd2;
		else if (value >= 10'd100) hund_n = 3'd1;
		else                       hund_n = 3'd0;
		hund_x100 = 10'({7'd0, hund_n} * 10'd100);
		rem_n     = 7'(value - hund_x100);
		tens_prod = 15'({8'd0, rem_n} * 15'd205);
		tens_n    = digit_t'(tens_prod[14:11]);
		tens_x10  = 7'({3'd0, tens_n} * 7'd10);
		units_n   = digit_t'(rem_n - tens_x10);
	end

	// hold the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1    <= req_type;
			pass_s1   <= sample_channel_passthrough;
			sample_s1 <= adc_sample;
		end
	end

	// update state and result as the word leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hund_q      <= 4'd0;
			tens_q      <= 4'd0;
			units_q     <= 4'd2;
			scan_q      <= SCAN_HUNDREDS;
			seg_q       <= 8'h00;
			dig_q       <= DIG_NONE;
			pass_q      <= 8'h00;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (req_s1 == REQ_SAMPLE) begin
					if (pass_s1) begin
						pass_q <= sample_s1;
					end else begin
						hund_q  <= {1'b0, hund_n};
						tens_q  <= tens_n;
						units_q <= units_n;
					end
				end else begin
					unique case (scan_q)
						SCAN_HUNDREDS: begin
							seg_q  <= seg_of(hund_q) | SEG_DP;
							dig_q  <= DIG_HUNDREDS;
							scan_q <= SCAN_TENS;
						end
						SCAN_TENS: begin
							seg_q  <= seg_of(tens_q);
							dig_q  <= DIG_TENS;
							scan_q <= SCAN_UNITS;
						end
						SCAN_UNITS: begin
							seg_q  <= seg_of(units_q);
							dig_q  <= DIG_UNITS;
							scan_q <= SCAN_HUNDREDS;
						end
						default: begin
							dig_q  <= DIG_NONE;
							scan_q <= SCAN_HUNDREDS;
						end
					endcase
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign segment_drive    = seg_q;
	assign digit_enable     = dig_q;
	assign passthrough_byte = pass_q;

	// at most one digit lit
	a_dig_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(dig_q))
		else $error("more than one digit enabled");

	// scan never rests at the idle code
	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q != SCAN_IDLE)
		else $error("scan position reached idle code");

	// decimal point only with the hundreds digit
	a_dp_hund: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_q == DIG_TENS || dig_q == DIG_UNITS) |-> !seg_q[7])
		else $error("decimal point lit off hundreds digit");

	a_dp_on: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_q == DIG_HUNDREDS) |-> seg_q[7])
		else $error("decimal point missing on hundreds digit");

	// a tick at the hundreds position moves the scan to the tens digit
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1 == REQ_TICK && scan_q == SCAN_HUNDREDS)
		|=> (scan_q == SCAN_TENS && dig_q == DIG_HUNDREDS))
		else $error("scan did not advance from hundreds");

	// stored digits stay decimal
	a_digits_dec: assert property (@(posedge clk) disable iff (!arst_n)
		hund_q <= 4'd5 && tens_q <= 4'd9 && units_q <= 4'd9)
		else $error("stored digit out of range");

endmodule
`default_nettype wire
